// ----- rtl/kpsd_pkg.sv -----
// ----------------------------------------------------------------------------
// kpsd_pkg
// Shared types, constants and the key character table for the keypad scanner
// with debounce.
// ----------------------------------------------------------------------------
package kpsd_pkg;

    localparam int ROW_COUNT = 4;
    localparam int COL_COUNT = 4;

    localparam int MATRIX_W  = 16;
    localparam int KEY_SLOTS = (ROW_COUNT * COL_COUNT > MATRIX_W) ?
                               MATRIX_W : ROW_COUNT * COL_COUNT;

    localparam int KEY_W    = 5;
    localparam int INDEX_W  = 4;
    localparam int CHAR_W   = 7;
    localparam int TIMER_W  = 16;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    typedef logic [KEY_W-1:0]   t_key;
    typedef logic [TIMER_W-1:0] t_ms;

    localparam t_key NO_KEY           = t_key'(16);
    localparam t_ms  DEBOUNCE_DEFAULT = t_ms'(40);
    localparam t_ms  MS_MAX           = '1;

    // register index, taken from paddr above the byte offset
    localparam logic REG_DEBOUNCE = 1'b0;

    typedef enum logic [1:0] {
        PH_SCAN     = 2'd0,
        PH_DETECTED = 2'd1,
        PH_PRESSED  = 2'd2,
        PH_RELEASED = 2'd3
    } t_phase;

    // first pressed key in row-major order, NO_KEY when none
    function automatic t_key first_key(input logic [MATRIX_W-1:0] matrix);
        t_key k;
        k = NO_KEY;
        for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
            if (matrix[i]) begin
                k = t_key'(i);
            end
        end
        return k;
    endfunction

    function automatic logic [CHAR_W-1:0] key_char(input logic [INDEX_W-1:0] idx);
        logic [CHAR_W-1:0] c;
        case (idx)
            4'd0:    c = 7'h31; // 1
            4'd1:    c = 7'h32; // 2
            4'd2:    c = 7'h33; // 3
            4'd3:    c = 7'h55; // U
            4'd4:    c = 7'h34; // 4
            4'd5:    c = 7'h35; // 5
            4'd6:    c = 7'h36; // 6
            4'd7:    c = 7'h4B; // K
            4'd8:    c = 7'h37; // 7
            4'd9:    c = 7'h38; // 8
            4'd10:   c = 7'h39; // 9
            4'd11:   c = 7'h57; // W
            4'd12:   c = 7'h50; // P
            4'd13:   c = 7'h30; // 0
            4'd14:   c = 7'h44; // D
            4'd15:   c = 7'h42; // B
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/keypad_scan_debounce_top.sv -----
// ----------------------------------------------------------------------------
// keypad_scan_debounce_top
// Debounced 4x4 matrix keypad scanner: priority encode, debounce state
// machine with millisecond timer, and one result per matrix sample.
// ----------------------------------------------------------------------------
// Each sample transfer (key matrix plus millisecond tick) yields exactly one
// result from the result register; a new sample is taken every cycle while the
// result register is empty or its result is being taken in the same cycle. The
// debounce state, timer and encoder sit between the input handshake and the
// result register, so the sustained rate is one sample per clock. A key is
// reported once, on the first sample in the pressed phase that shows no key at
// all. The user writes the debounce time (register 0, in millisecond ticks,
// reset value 40) over APB only with no sample in flight; nothing enforces it.
module keypad_scan_debounce_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [kpsd_pkg::APB_AW-1:0]    paddr,
    input  logic [kpsd_pkg::APB_DW-1:0]    pwdata,
    output logic [kpsd_pkg::APB_DW-1:0]    prdata,
    output logic                           pready,

    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [kpsd_pkg::MATRIX_W-1:0]  i_key_matrix,
    input  logic                           i_ms_tick,

    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_key_event,
    output logic [kpsd_pkg::INDEX_W-1:0]   o_key_index,
    output logic [kpsd_pkg::CHAR_W-1:0]    o_key_char
);
    import kpsd_pkg::*;

    t_ms                r_debounce_ms;
    t_phase             r_phase, n_phase;
    t_key               r_held_key, n_held_key;
    t_ms                r_elapsed_ms, n_elapsed_ms;
    logic               r_timer_run, n_timer_run;
    logic               r_out_valid;
    logic               r_key_event, n_key_event;
    logic [INDEX_W-1:0] r_key_index, n_key_index;
    logic [CHAR_W-1:0]  r_key_char, n_key_char;

    logic               in_xfer;
    logic               cfg_wr;
    t_key               seen;
    t_ms                ms_now;
    logic               timer_done;
    logic               do_check;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr[APB_AW-1] == REG_DEBOUNCE) ?
                    APB_DW'(r_debounce_ms) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= DEBOUNCE_DEFAULT;
        end else if (cfg_wr && paddr[APB_AW-1] == REG_DEBOUNCE) begin
            r_debounce_ms <= pwdata[TIMER_W-1:0];
        end
    end

    // handshake
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    assign seen = first_key(i_key_matrix);

    // timer advances before the phase logic looks at it
    assign ms_now = (r_timer_run && i_ms_tick && r_elapsed_ms != MS_MAX) ?
                    r_elapsed_ms + t_ms'(1) : r_elapsed_ms;
    assign timer_done = r_timer_run && (ms_now >= r_debounce_ms);

    // next state
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_SCAN: begin
                if (seen != NO_KEY) begin
                    n_phase = PH_DETECTED;
                end
            end
            PH_DETECTED: begin
                if (timer_done) begin
                    n_phase = (seen == r_held_key) ? PH_PRESSED : PH_SCAN;
                end
            end
            PH_PRESSED: begin
                if (seen != r_held_key) begin
                    n_phase = PH_RELEASED;
                end
            end
            PH_RELEASED: begin
                if (timer_done) begin
                    n_phase = (seen != NO_KEY && seen == r_held_key) ?
                              PH_PRESSED : PH_SCAN;
                end
            end
            default: n_phase = PH_SCAN;
        endcase
    end

    // outputs: held key, timer, result
    always_comb begin
        n_held_key  = r_held_key;
        n_key_event = 1'b0;
        do_check    = 1'b0;
        case (r_phase)
            PH_SCAN: begin
                if (seen != NO_KEY) begin
                    n_held_key = seen;
                    do_check   = 1'b1;
                end
            end
            PH_DETECTED: do_check = 1'b1;
            PH_PRESSED: begin
                if (seen != r_held_key) begin
                    do_check    = 1'b1;
                    n_key_event = (seen == NO_KEY);
                end
            end
            PH_RELEASED: do_check = 1'b1;
            default: do_check = 1'b0;
        endcase

        n_elapsed_ms = ms_now;
        n_timer_run  = r_timer_run;
        if (do_check) begin
            if (!r_timer_run) begin
                n_timer_run  = 1'b1;
                n_elapsed_ms = '0;
            end else if (timer_done) begin
                n_timer_run = 1'b0;
            end
        end

        n_key_index = n_key_event ? r_held_key[INDEX_W-1:0] : '0;
        n_key_char  = n_key_event ? key_char(r_held_key[INDEX_W-1:0]) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SCAN;
            r_held_key   <= NO_KEY;
            r_elapsed_ms <= '0;
            r_timer_run  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_phase      <= n_phase;
                r_held_key   <= n_held_key;
                r_elapsed_ms <= n_elapsed_ms;
                r_timer_run  <= n_timer_run;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_key_event <= n_key_event;
            r_key_index <= n_key_index;
            r_key_char  <= n_key_char;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_key_event = r_key_event;
    assign o_key_index = r_key_index;
    assign o_key_char  = r_key_char;

`ifndef SYNTHESIS
    // a reported key always leaves the block in release confirmation
    a_event_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_key_event) |-> (r_phase == PH_RELEASED))
        else $error("key event without entering release phase");

    a_quiet_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_key_event) |-> (r_key_index == '0 && r_key_char == '0))
        else $error("nonzero key fields without event");

    // timer runs exactly in the two confirmation phases
    a_timer_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_timer_run == (r_phase == PH_DETECTED || r_phase == PH_RELEASED))
        else $error("timer state disagrees with phase");

    a_held_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_SCAN) |-> (r_held_key < NO_KEY))
        else $error("no held key outside scan phase");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_phase)))
        else $error("state moved while result stalled");
`endif

endmodule

// ----- dv/keypad_scan_debounce_top_tb.sv -----
// ----------------------------------------------------------------------------
// keypad_scan_debounce_top_tb
// Drives matrix samples through the keypad scanner with random gaps and
// output stalls. A cycle-free model of the scan and debounce state machine
// predicts one result per sample, and each result is checked field by field.
// The debounce time is changed over APB between phases, from zero to the top
// of its range.
// ----------------------------------------------------------------------------
module keypad_scan_debounce_top_tb;
    import kpsd_pkg::*;

    typedef struct packed {
        logic [MATRIX_W-1:0] matrix;
        logic                tick;
    } sample_t;

    typedef struct packed {
        logic               evt;
        logic [INDEX_W-1:0] idx;
        logic [CHAR_W-1:0]  chr;
    } report_t;

    // legend of the 4x4 pad in row-major order, first key in the top byte
    localparam logic [8*16-1:0] KEY_GLYPHS = "123U456K789WP0DB";

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 psel         = 1'b0;
    logic                 penable      = 1'b0;
    logic                 pwrite       = 1'b0;
    logic [APB_AW-1:0]    paddr        = '0;
    logic [APB_DW-1:0]    pwdata       = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;
    logic                 i_in_valid   = 1'b0;
    logic                 o_in_ready;
    logic [MATRIX_W-1:0]  i_key_matrix = '0;
    logic                 i_ms_tick    = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready  = 1'b0;
    logic                 o_key_event;
    logic [INDEX_W-1:0]   o_key_index;
    logic [CHAR_W-1:0]    o_key_char;

    sample_t matrix_samples[$];
    report_t pending_reports[$];
    int      n_queued   = 0;
    int      n_fail     = 0;
    int      drv_gap    = 0;
    int      rcv_stall  = 0;
    bit      allow_gaps = 1'b0;

    // scanner state as seen by the predictor
    t_phase kp_phase    = PH_SCAN;
    t_key   kp_held     = NO_KEY;
    t_ms    kp_elapsed  = '0;
    logic   kp_timing   = 1'b0;
    t_ms    kp_debounce = DEBOUNCE_DEFAULT;

    keypad_scan_debounce_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_key_matrix (i_key_matrix),
        .i_ms_tick    (i_ms_tick),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_key_event  (o_key_event),
        .o_key_index  (o_key_index),
        .o_key_char   (o_key_char)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_key lowest_pressed(input logic [MATRIX_W-1:0] m);
        t_key found;
        found = NO_KEY;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if (found == NO_KEY && m[i]) begin
                found = t_key'(i);
            end
        end
        return found;
    endfunction

    function automatic logic [CHAR_W-1:0] glyph_of(input logic [INDEX_W-1:0] idx);
        return KEY_GLYPHS[8*(15-idx) +: CHAR_W];
    endfunction

    // a stopped timer starts and answers not yet; a running one stops once due
    function automatic logic debounce_settled();
        if (!kp_timing) begin
            kp_timing  = 1'b1;
            kp_elapsed = '0;
            return 1'b0;
        end
        if (kp_elapsed >= kp_debounce) begin
            kp_timing = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic report_t predict_report(input sample_t s);
        report_t r;
        t_key    seen;
        r = '0;
        if (kp_timing && s.tick && kp_elapsed != MS_MAX) begin
            kp_elapsed = kp_elapsed + 1'b1;
        end
        case (kp_phase)
            PH_SCAN: begin
                seen = lowest_pressed(s.matrix);
                if (seen != NO_KEY) begin
                    kp_held  = seen;
                    kp_phase = PH_DETECTED;
                    void'(debounce_settled());
                end
            end
            PH_DETECTED: begin
                if (debounce_settled()) begin
                    seen     = lowest_pressed(s.matrix);
                    kp_phase = (seen == kp_held) ? PH_PRESSED : PH_SCAN;
                end
            end
            PH_PRESSED: begin
                seen = lowest_pressed(s.matrix);
                if (seen != kp_held) begin
                    // only a release to no key at all is reported
                    if (seen == NO_KEY) begin
                        r.evt = 1'b1;
                        r.idx = kp_held[INDEX_W-1:0];
                        r.chr = glyph_of(kp_held[INDEX_W-1:0]);
                    end
                    kp_phase = PH_RELEASED;
                    void'(debounce_settled());
                end
            end
            default: begin
                if (debounce_settled()) begin
                    seen     = lowest_pressed(s.matrix);
                    kp_phase = (seen != NO_KEY && seen == kp_held) ? PH_PRESSED : PH_SCAN;
                end
            end
        endcase
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        n_fail++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end
        if (r < 93) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 80);
    endfunction

    always @(posedge i_clk) begin : sample_driver
        sample_t cur;
        sample_t nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                cur.matrix = i_key_matrix;
                cur.tick   = i_ms_tick;
                pending_reports.push_back(predict_report(cur));
            end
            if (i_in_valid && !o_in_ready) begin
                // hold the transfer until it is taken
            end else if (drv_gap > 0) begin
                drv_gap--;
                i_in_valid <= 1'b0;
            end else if (matrix_samples.size() != 0) begin
                nxt = matrix_samples.pop_front();
                i_key_matrix <= nxt.matrix;
                i_ms_tick    <= nxt.tick;
                i_in_valid   <= 1'b1;
                if (allow_gaps && $urandom_range(0, 99) < 25) begin
                    drv_gap = pick_gap();
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : report_monitor
        report_t want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_reports.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result event=%0b index=%0d char=%02h",
                                            o_key_event, o_key_index, o_key_char));
                end else begin
                    want = pending_reports.pop_front();
                    if (o_key_event !== want.evt) begin
                        flag_mismatch($sformatf("key_event got %0b want %0b",
                                                o_key_event, want.evt));
                    end
                    if (o_key_index !== want.idx) begin
                        flag_mismatch($sformatf("key_index got %0d want %0d",
                                                o_key_index, want.idx));
                    end
                    if (o_key_char !== want.chr) begin
                        flag_mismatch($sformatf("key_char got %02h want %02h",
                                                o_key_char, want.chr));
                    end
                end
            end
            if (rcv_stall > 0) begin
                rcv_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (allow_gaps && $urandom_range(0, 99) < 20) begin
                    rcv_stall = pick_gap();
                end
            end
        end
    end

    task automatic push_sample(input logic [MATRIX_W-1:0] m, input logic t);
        sample_t s;
        s.matrix = m;
        s.tick   = t;
        matrix_samples.push_back(s);
        n_queued++;
    endtask

    // bounce, hold long enough to confirm, release, hold released
    task automatic add_keystroke();
        int                  k;
        int                  j;
        int                  ticks;
        logic                t;
        logic [MATRIX_W-1:0] held;
        logic [MATRIX_W-1:0] other;
        k    = $urandom_range(0, 15);
        held = 16'h1 << k;
        if ($urandom_range(0, 1)) begin
            held = held | (16'($urandom) & (16'hFFFF << k));
        end
        repeat ($urandom_range(0, 3)) begin
            push_sample(16'($urandom), 1'($urandom_range(0, 1)));
        end
        ticks = 0;
        while (ticks < int'(kp_debounce) + 2) begin
            t = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 39) == 0) begin
                push_sample(16'($urandom), t);
            end else begin
                push_sample(held, t);
            end
            ticks += int'(t);
        end
        other = '0;
        if ($urandom_range(0, 4) == 0) begin
            j     = (k + $urandom_range(1, 15)) % 16;
            other = 16'h1 << j;
        end
        push_sample(other, 1'($urandom_range(0, 1)));
        ticks = 0;
        while (ticks < int'(kp_debounce) + 2) begin
            t = ($urandom_range(0, 3) != 0);
            push_sample(($urandom_range(0, 9) == 0) ? other : '0, t);
            ticks += int'(t);
        end
    endtask

    task automatic add_noise();
        repeat ($urandom_range(1, 8)) begin
            push_sample($urandom_range(0, 1) ? 16'($urandom) : '0,
                        1'($urandom_range(0, 1)));
        end
    endtask

    task automatic drain_all();
        while (matrix_samples.size() != 0 || i_in_valid || pending_reports.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_phase(input int n_items);
        int target;
        target = n_queued + n_items;
        while (n_queued < target) begin
            if ($urandom_range(0, 9) < 7) begin
                add_keystroke();
            end else begin
                add_noise();
            end
        end
        drain_all();
    endtask

    task automatic write_debounce(input t_ms v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_DEBOUNCE, 2'b00};
        pwdata  <= APB_DW'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        kp_debounce = v;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        allow_gaps = 1'b1;

        // reset debounce time
        run_phase(180);

        // zero debounce: each step of the state machine is visible at once
        write_debounce(t_ms'(0));
        push_sample(16'h0000, 1'b0);
        push_sample(16'h0001, 1'b1);
        push_sample(16'h0001, 1'b0);
        push_sample(16'h0001, 1'b1);
        push_sample(16'h0000, 1'b0);
        push_sample(16'h0000, 1'b0);
        push_sample(16'h8000, 1'b1);
        push_sample(16'h8000, 1'b1);
        push_sample(16'h0000, 1'b1);
        push_sample(16'h0000, 1'b0);
        push_sample(16'hFFFF, 1'b1);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'h0008, 1'b0);
        push_sample(16'h0008, 1'b1);
        push_sample(16'h0008, 1'b0);
        push_sample(16'h0008, 1'b0);
        // release onto another key gives no report
        push_sample(16'h0020, 1'b0);
        push_sample(16'h0008, 1'b0);
        push_sample(16'h0000, 1'b0);
        push_sample(16'h0000, 1'b0);
        push_sample(16'h5555, 1'b1);
        push_sample(16'hAAAA, 1'b0);
        push_sample(16'hAAAA, 1'b1);
        push_sample(16'hAAAA, 1'b0);
        push_sample(16'h0000, 1'b1);
        drain_all();
        run_phase(150);

        write_debounce(t_ms'(1));
        run_phase(180);

        write_debounce(t_ms'(2));
        run_phase(180);

        // back-to-back stretch with no gaps or stalls
        allow_gaps = 1'b0;
        write_debounce(t_ms'($urandom_range(3, 9)));
        run_phase(150);

        // longest debounce: a press that stays unconfirmed, then release
        write_debounce(MS_MAX);
        repeat (24) push_sample(16'hF080, 1'b1);
        push_sample(16'h0000, 1'b0);
        repeat (3) push_sample(16'h0000, 1'b1);
        drain_all();
        allow_gaps = 1'b1;

        write_debounce(DEBOUNCE_DEFAULT);
        run_phase(200);

        repeat (10) @(posedge i_clk);
        if (pending_reports.size() != 0) begin
            flag_mismatch($sformatf("%0d results never arrived", pending_reports.size()));
        end
        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("TIMEOUT: run did not finish");
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/kpsd_pkg.sv
rtl/keypad_scan_debounce_top.sv
dv/keypad_scan_debounce_top_tb.sv
